>>> hw/rtl/cshs_pkg.sv
package cshs_pkg;

   localparam int TABLE_DEPTH = 2048;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int PROBE_W     = SLOT_W + 1;
   localparam bit DEPTH_POW2  = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

   localparam int HASH_W      = 32;
   localparam int HALF_W      = 16;
   localparam int HALF_CNT_W  = 2;
   localparam int KEY_W       = 64;
   localparam int COUNT_W     = 64;
   localparam int SLOT_OUT_W  = 11;
   localparam int PROBE_OUT_W = 12;
   localparam int STATUS_W    = 2;

   localparam logic [HASH_W-1:0] DEPTH_HASH = HASH_W'(TABLE_DEPTH);
   localparam logic [HASH_W-1:0] MOD_RECIP  = HASH_W'((64'd1 << HASH_W) / TABLE_DEPTH);

   localparam int MIX_SHL     = 10;
   localparam int MIX_SHR     = 6;
   localparam int FIN_SHL_A   = 3;
   localparam int FIN_SHR     = 11;
   localparam int FIN_SHL_B   = 15;

   localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UPDATED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

   typedef struct packed {
      logic [31:0]        agent_address;
      logic [31:0]        interface_index;
      logic [COUNT_W-1:0] octets_in;
      logic [COUNT_W-1:0] octets_out;
      logic [COUNT_W-1:0] link_speed;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    store_status;
      logic [SLOT_OUT_W-1:0]  slot_used;
      logic [PROBE_OUT_W-1:0] probes_taken;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] octets_in;
      logic [COUNT_W-1:0] octets_out;
      logic [COUNT_W-1:0] link_speed;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MIX,
      ST_MOD,
      ST_REM,
      ST_PROBE
   } state_type;

   function automatic logic [HASH_W-1:0] oaat_step(input logic [HASH_W-1:0] h,
                                                   input logic [HALF_W-1:0] half);
      logic [HASH_W-1:0] a;
      a = h + HASH_W'(half);
      a = a + (a << MIX_SHL);
      return a ^ (a >> MIX_SHR);
   endfunction

   function automatic logic [HASH_W-1:0] oaat_final(input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] a;
      a = h + (h << FIN_SHL_A);
      a = a ^ (a >> FIN_SHR);
      return a + (a << FIN_SHL_B);
   endfunction

endpackage

>>> hw/rtl/cshs_ram.sv
module cshs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/counter_sample_hash_store_core.sv
// Keyed store for interface counter samples, indexed by (agent, interface).
// Request channel (req_valid / req_stall / req_data) carries one sample per
// transaction; response channel (rsp_valid / rsp_stall / rsp_data) returns one
// status, slot and probe count per sample, in order.
// One sample is processed at a time. A depth that is not a power of two adds
// modulo reduction by reciprocal multiplication (states ST_MOD, ST_REM). The
// hash takes one key half per cycle and the probe loop reads one table entry
// per cycle through the single registered-read port of the entry memory.
// After reset the block sweeps the table, clearing one entry per cycle across
// all TABLE_DEPTH entries (2048 by default); req_stall stays high meanwhile.
// A finished response waits in an output register; a new sample is taken
// while it waits. If the response is still stalled when the next sample
// reaches its decision, the block holds that decision and keeps req_stall
// high until the response register frees up.
module counter_sample_hash_store_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cshs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cshs_pkg::rsp_type rsp_data
);

   import cshs_pkg::*;

   localparam logic [SLOT_W-1:0]     SLOT_LAST  = SLOT_W'(TABLE_DEPTH - 1);
   localparam logic [PROBE_W-1:0]    PROBE_LAST = PROBE_W'(TABLE_DEPTH - 1);
   localparam logic [HALF_CNT_W-1:0] HALF_LAST  = HALF_CNT_W'(3);

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [HASH_W-1:0]       hash_ff, hash_in;
   logic [HALF_CNT_W-1:0]   half_cnt_ff, half_cnt_in;
   logic [HASH_W-1:0]       quot_ff, quot_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [PROBE_W-1:0]      probe_ff, probe_in;
   logic [SLOT_W-1:0]       clr_cnt_ff, clr_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    ram_wr_en;
   logic [SLOT_W-1:0]       ram_wr_addr;
   entry_type               ram_wr_data;
   logic [SLOT_W-1:0]       ram_rd_addr;
   entry_type               ram_rd_data;

   logic [HALF_W-1:0]       halves [4];
   logic [KEY_W-1:0]        key;
   logic                    match;
   logic                    rsp_free;
   logic [HASH_W-1:0]       fin_hash;
   logic [2*HASH_W-1:0]     mod_prod;
   logic [HASH_W-1:0]       rem_wide;
   logic [SLOT_W-1:0]       rem_slot;
   logic [SLOT_W-1:0]       slot_next;

   cshs_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         half_cnt_ff  <= '0;
         probe_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         half_cnt_ff  <= half_cnt_in;
         probe_ff     <= probe_in;
      end
      req_ff  <= req_in;
      hash_ff <= hash_in;
      quot_ff <= quot_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      key       = {req_ff.agent_address, req_ff.interface_index};
      halves[0] = req_ff.agent_address[31:16];
      halves[1] = req_ff.agent_address[15:0];
      halves[2] = req_ff.interface_index[31:16];
      halves[3] = req_ff.interface_index[15:0];
      match     = !ram_rd_data.valid || (ram_rd_data.key == key);
      rsp_free  = !rsp_valid_ff || !rsp_stall;
      fin_hash  = oaat_final(hash_ff);
      mod_prod  = (2*HASH_W)'(hash_ff) * (2*HASH_W)'(MOD_RECIP);
      rem_wide  = hash_ff - HASH_W'(quot_ff * DEPTH_HASH);
      rem_slot  = (rem_wide >= DEPTH_HASH) ? SLOT_W'(rem_wide - DEPTH_HASH)
                                           : SLOT_W'(rem_wide);
      slot_next = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;

      state_in     = state_ff;
      req_in       = req_ff;
      hash_in      = hash_ff;
      half_cnt_in  = half_cnt_ff;
      quot_in      = quot_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      req_stall    = 1'b1;

      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_ff;
      ram_wr_data = '{valid:      1'b1,
                      key:        key,
                      octets_in:  req_ff.octets_in,
                      octets_out: req_ff.octets_out,
                      link_speed: req_ff.link_speed};
      ram_rd_addr = slot_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SLOT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in      = req_data;
               hash_in     = '0;
               half_cnt_in = '0;
               state_in    = ST_HASH;
            end
         end
         ST_HASH: begin
            hash_in     = oaat_step(hash_ff, halves[half_cnt_ff]);
            half_cnt_in = half_cnt_ff + 1'b1;
            if (half_cnt_ff == HALF_LAST) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            if (DEPTH_POW2) begin
               ram_rd_addr = fin_hash[SLOT_W-1:0];
               slot_in     = fin_hash[SLOT_W-1:0];
               probe_in    = '0;
               state_in    = ST_PROBE;
            end else begin
               hash_in  = fin_hash;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            quot_in  = mod_prod[2*HASH_W-1:HASH_W];
            state_in = ST_REM;
         end
         ST_REM: begin
            ram_rd_addr = rem_slot;
            slot_in     = rem_slot;
            probe_in    = '0;
            state_in    = ST_PROBE;
         end
         ST_PROBE: begin
            if (match) begin
               if (rsp_free) begin
                  ram_wr_en              = 1'b1;
                  rsp_valid_in           = 1'b1;
                  rsp_in.store_status    = ram_rd_data.valid ? STATUS_UPDATED : STATUS_STORED;
                  rsp_in.slot_used       = SLOT_OUT_W'(slot_ff);
                  rsp_in.probes_taken    = PROBE_OUT_W'(probe_ff);
                  state_in               = ST_IDLE;
               end
            end else if (probe_ff == PROBE_LAST) begin
               if (rsp_free) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.store_status = STATUS_DROPPED;
                  rsp_in.slot_used    = SLOT_OUT_W'(slot_ff);
                  rsp_in.probes_taken = PROBE_OUT_W'(TABLE_DEPTH);
                  state_in            = ST_IDLE;
               end
            end else begin
               ram_rd_addr = slot_next;
               slot_in     = slot_next;
               probe_in    = probe_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (probe_ff <= PROBE_LAST))
      else $error("probe count past table depth");

   a_write_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE && ram_wr_en) |-> rsp_free)
      else $error("entry written while response register is blocked");

   a_rsp_from_probe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PROBE))
      else $error("response raised outside the probe loop");

   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled response changed");
`endif

endmodule
